// ===== sv/mpenc_pkg.sv =====
package mpenc_pkg;

    localparam int QueueDepthDefault = 2;

    localparam logic [3:0] KIND_NIL   = 4'd0;
    localparam logic [3:0] KIND_BOOL  = 4'd1;
    localparam logic [3:0] KIND_INT   = 4'd2;
    localparam logic [3:0] KIND_UINT  = 4'd3;
    localparam logic [3:0] KIND_F32   = 4'd4;
    localparam logic [3:0] KIND_F64   = 4'd5;
    localparam logic [3:0] KIND_STR   = 4'd6;
    localparam logic [3:0] KIND_BIN   = 4'd7;
    localparam logic [3:0] KIND_ARRAY = 4'd8;
    localparam logic [3:0] KIND_MAP   = 4'd9;
    localparam logic [3:0] KIND_RAW   = 4'd10;

    localparam logic [7:0] TAG_NIL      = 8'hc0;
    localparam logic [7:0] TAG_FALSE    = 8'hc2;
    localparam logic [7:0] TAG_TRUE     = 8'hc3;
    localparam logic [7:0] TAG_BIN8     = 8'hc4;
    localparam logic [7:0] TAG_BIN16    = 8'hc5;
    localparam logic [7:0] TAG_BIN32    = 8'hc6;
    localparam logic [7:0] TAG_F32      = 8'hca;
    localparam logic [7:0] TAG_F64      = 8'hcb;
    localparam logic [7:0] TAG_UINT8    = 8'hcc;
    localparam logic [7:0] TAG_UINT16   = 8'hcd;
    localparam logic [7:0] TAG_UINT32   = 8'hce;
    localparam logic [7:0] TAG_UINT64   = 8'hcf;
    localparam logic [7:0] TAG_INT8     = 8'hd0;
    localparam logic [7:0] TAG_INT16    = 8'hd1;
    localparam logic [7:0] TAG_INT32    = 8'hd2;
    localparam logic [7:0] TAG_INT64    = 8'hd3;
    localparam logic [7:0] TAG_STR8     = 8'hd9;
    localparam logic [7:0] TAG_STR16    = 8'hda;
    localparam logic [7:0] TAG_STR32    = 8'hdb;
    localparam logic [7:0] TAG_ARRAY16  = 8'hdc;
    localparam logic [7:0] TAG_ARRAY32  = 8'hdd;
    localparam logic [7:0] TAG_MAP16    = 8'hde;
    localparam logic [7:0] TAG_MAP32    = 8'hdf;
    localparam logic [7:0] TAG_FIXSTR   = 8'ha0;
    localparam logic [7:0] TAG_FIXARRAY = 8'h90;
    localparam logic [7:0] TAG_FIXMAP   = 8'h80;

    // First byte, then nbytes of payload taken from the top of payload.
    typedef struct packed {
        logic [7:0]  tag;
        logic [63:0] payload;
        logic [3:0]  nbytes;
    } t_enc_desc;

    typedef struct packed {
        logic      empty;
        t_enc_desc head;
    } t_q_rd;

endpackage

// ===== sv/mpenc_front.sv =====
module mpenc_front (
    input  logic [3:0]            i_req_type,
    input  logic [63:0]           i_value,
    output logic                  o_known,
    output mpenc_pkg::t_enc_desc  o_desc
);
    import mpenc_pkg::*;

    logic [31:0] len;
    logic [7:0]  tag;
    logic [3:0]  nb;
    logic        known;

    assign len = i_value[31:0];

    always_comb begin
        tag   = TAG_NIL;
        nb    = 4'd0;
        known = 1'b1;
        unique case (i_req_type)
            KIND_NIL: begin
                tag = TAG_NIL;
            end
            KIND_BOOL: begin
                tag = (i_value != 64'd0) ? TAG_TRUE : TAG_FALSE;
            end
            KIND_INT, KIND_UINT: begin
                if (i_req_type == KIND_INT && i_value[63]) begin
                    if (&i_value[63:5]) begin
                        tag = i_value[7:0];
                    end else if (&i_value[63:7]) begin
                        tag = TAG_INT8;
                        nb  = 4'd1;
                    end else if (&i_value[63:15]) begin
                        tag = TAG_INT16;
                        nb  = 4'd2;
                    end else if (&i_value[63:31]) begin
                        tag = TAG_INT32;
                        nb  = 4'd4;
                    end else begin
                        tag = TAG_INT64;
                        nb  = 4'd8;
                    end
                end else if (i_value[63:7] == '0) begin
                    tag = i_value[7:0];
                end else if (i_value[63:8] == '0) begin
                    tag = TAG_UINT8;
                    nb  = 4'd1;
                end else if (i_value[63:16] == '0) begin
                    tag = TAG_UINT16;
                    nb  = 4'd2;
                end else if (i_value[63:32] == '0) begin
                    tag = TAG_UINT32;
                    nb  = 4'd4;
                end else begin
                    tag = TAG_UINT64;
                    nb  = 4'd8;
                end
            end
            KIND_F32: begin
                tag = TAG_F32;
                nb  = 4'd4;
            end
            KIND_F64: begin
                tag = TAG_F64;
                nb  = 4'd8;
            end
            KIND_STR: begin
                if (len[31:5] == '0) begin
                    tag = TAG_FIXSTR | {3'd0, len[4:0]};
                end else if (len[31:8] == '0) begin
                    tag = TAG_STR8;
                    nb  = 4'd1;
                end else if (len[31:16] == '0) begin
                    tag = TAG_STR16;
                    nb  = 4'd2;
                end else begin
                    tag = TAG_STR32;
                    nb  = 4'd4;
                end
            end
            KIND_BIN: begin
                if (len[31:8] == '0) begin
                    tag = TAG_BIN8;
                    nb  = 4'd1;
                end else if (len[31:16] == '0) begin
                    tag = TAG_BIN16;
                    nb  = 4'd2;
                end else begin
                    tag = TAG_BIN32;
                    nb  = 4'd4;
                end
            end
            KIND_ARRAY, KIND_MAP: begin
                if (len[31:4] == '0) begin
                    tag = ((i_req_type == KIND_MAP) ? TAG_FIXMAP : TAG_FIXARRAY)
                          | {4'd0, len[3:0]};
                end else if (len[31:16] == '0) begin
                    tag = (i_req_type == KIND_MAP) ? TAG_MAP16 : TAG_ARRAY16;
                    nb  = 4'd2;
                end else begin
                    tag = (i_req_type == KIND_MAP) ? TAG_MAP32 : TAG_ARRAY32;
                    nb  = 4'd4;
                end
            end
            KIND_RAW: begin
                tag = i_value[7:0];
            end
            default: begin
                known = 1'b0;
            end
        endcase
    end

    // left-align the payload so the back end always sends the top byte first
    always_comb begin
        case (nb)
            4'd1:    o_desc.payload = {i_value[7:0], 56'd0};
            4'd2:    o_desc.payload = {i_value[15:0], 48'd0};
            4'd4:    o_desc.payload = {i_value[31:0], 32'd0};
            default: o_desc.payload = i_value;
        endcase
    end

    assign o_desc.tag    = tag;
    assign o_desc.nbytes = nb;
    assign o_known       = known;

endmodule

// ===== sv/mpenc_queue.sv =====
module mpenc_queue #(
    parameter int DEPTH = mpenc_pkg::QueueDepthDefault
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_wr,
    input  mpenc_pkg::t_enc_desc  i_wr_desc,
    output logic                  o_full,
    input  logic                  i_rd,
    output mpenc_pkg::t_q_rd      o_rd
);
    import mpenc_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_enc_desc       r_mem [DEPTH];
    logic [PW-1:0]   r_wptr, n_wptr;
    logic [PW-1:0]   r_rptr, n_rptr;
    logic [CW-1:0]   r_cnt,  n_cnt;

    always_comb begin
        n_wptr = r_wptr;
        n_rptr = r_rptr;
        n_cnt  = r_cnt;
        if (i_wr) begin
            n_wptr = (r_wptr == PW'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
        end
        if (i_rd) begin
            n_rptr = (r_rptr == PW'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
        end
        if (i_wr && !i_rd) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_wr && i_rd) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wptr] <= i_wr_desc;
        end
    end

    assign o_full     = (r_cnt == CW'(DEPTH));
    assign o_rd.empty = (r_cnt == '0);
    assign o_rd.head  = r_mem[r_rptr];

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_wr && o_full))
        else $error("queue written while full");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_rd && o_rd.empty))
        else $error("queue read while empty");
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(DEPTH))
        else $error("queue count out of range");

endmodule

// ===== sv/mpenc_back.sv =====
module mpenc_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  mpenc_pkg::t_q_rd   i_q,
    output logic               o_q_rd,
    output logic [7:0]         o_out_byte,
    output logic               o_last,
    output logic               empty,
    input  logic               pop
);
    import mpenc_pkg::*;

    logic        r_ov,   n_ov;
    logic [7:0]  r_byte, n_byte;
    logic        r_last, n_last;
    logic        r_act,  n_act;
    logic [63:0] r_pay,  n_pay;
    logic [3:0]  r_rem,  n_rem;
    logic        adv;
    logic        q_rd;

    assign adv = !r_ov || pop;

    always_comb begin
        n_ov   = r_ov;
        n_byte = r_byte;
        n_last = r_last;
        n_act  = r_act;
        n_pay  = r_pay;
        n_rem  = r_rem;
        q_rd   = 1'b0;
        if (adv) begin
            if (r_act) begin
                n_ov   = 1'b1;
                n_byte = r_pay[63:56];
                n_last = (r_rem == 4'd1);
                n_pay  = {r_pay[55:0], 8'd0};
                n_rem  = r_rem - 4'd1;
                n_act  = (r_rem != 4'd1);
            end else if (!i_q.empty) begin
                q_rd   = 1'b1;
                n_ov   = 1'b1;
                n_byte = i_q.head.tag;
                n_last = (i_q.head.nbytes == 4'd0);
                n_act  = (i_q.head.nbytes != 4'd0);
                n_pay  = i_q.head.payload;
                n_rem  = i_q.head.nbytes;
            end else begin
                n_ov = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov  <= 1'b0;
            r_act <= 1'b0;
            r_rem <= '0;
        end else begin
            r_ov  <= n_ov;
            r_act <= n_act;
            r_rem <= n_rem;
        end
    end

    always_ff @(posedge i_clk) begin
        r_byte <= n_byte;
        r_last <= n_last;
        r_pay  <= n_pay;
    end

    assign o_q_rd     = q_rd;
    assign o_out_byte = r_byte;
    assign o_last     = r_last;
    assign empty      = !r_ov;

    a_act_has_bytes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_act |-> (r_rem != 4'd0))
        else $error("active transaction with no payload bytes left");
    a_act_has_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_act |-> (r_ov && !r_last))
        else $error("payload pending behind a missing or final byte");
    a_no_fetch_mid_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_act |-> !q_rd)
        else $error("next item fetched before current one finished");

endmodule

// ===== sv/messagepack_value_encoder_core.sv =====
// MessagePack value encoder.
// Input side is a queue write port: present i_req_type and i_value with push;
// the transaction is taken on a clock edge where push is high and full is low.
// Request kinds outside nil..raw byte are taken and dropped without output.
// Output side is a queue read port: while empty is low, o_out_byte and o_last
// show the oldest byte of the encoded stream; pop takes it. o_last marks the
// final byte of each request's encoding.
// A classifier picks the tag and payload length for the shortest form and
// writes a descriptor into a small queue (QUEUE_DEPTH entries); a serialiser
// reads descriptors and sends one byte per cycle through an output register.
// The first byte of a request passes through the queue and then the output
// register. Each request encodes to 1 + n bytes, n = payload bytes (0, 1, 2, 4
// or 8), so 1 to 9 bytes; the queue takes new requests while bytes go out.
// When pop is held low the output byte holds, the serialiser stops and the
// queue fills; full then stalls the input. Synchronous reset empties the
// queue and the output register; no other state is kept.
module messagepack_value_encoder_core #(
    parameter int QUEUE_DEPTH = mpenc_pkg::QueueDepthDefault
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [3:0]  i_req_type,
    input  logic [63:0] i_value,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  o_out_byte,
    output logic        o_last
);
    import mpenc_pkg::*;

    logic      known;
    t_enc_desc desc;
    logic      q_full;
    logic      q_wr;
    logic      q_rd;
    t_q_rd     q_rd_bus;

    mpenc_front u_front (
        .i_req_type (i_req_type),
        .i_value    (i_value),
        .o_known    (known),
        .o_desc     (desc)
    );

    assign q_wr = push && !q_full && known;

    mpenc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (q_wr),
        .i_wr_desc (desc),
        .o_full    (q_full),
        .i_rd      (q_rd),
        .o_rd      (q_rd_bus)
    );

    mpenc_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q        (q_rd_bus),
        .o_q_rd     (q_rd),
        .o_out_byte (o_out_byte),
        .o_last     (o_last),
        .empty      (empty),
        .pop        (pop)
    );

    assign full = q_full;

endmodule
